@@ hdl/bresenham_line_2x2_stamper_unit_defines.svh @@
// Assertion macros used by the checker of the stamper unit.
`ifndef BRESENHAM_LINE_2X2_STAMPER_UNIT_DEFINES_SVH
`define BRESENHAM_LINE_2X2_STAMPER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BLSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BLSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/blss_pkg.sv @@
`default_nettype none

package blss_pkg;

	localparam int COLOR_BITS = 16;

	typedef enum logic {
		ACT_LOAD = 1'b0,
		ACT_STEP = 1'b1
	} action_t;

endpackage

`default_nettype wire

@@ hdl/blss_cmd_if.sv @@
`default_nettype none

interface blss_cmd_if #(
	parameter int COORD_BITS = 13
);
	logic                         valid;
	logic                         ready;
	logic                         action;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;
	logic [15:0]                  pen_color;

	modport source (
		output valid, action, start_x, start_y, end_x, end_y, pen_color,
		input  ready
	);

	modport sink (
		input  valid, action, start_x, start_y, end_x, end_y, pen_color,
		output ready
	);
endinterface

`default_nettype wire

@@ hdl/blss_res_if.sv @@
`default_nettype none

interface blss_res_if #(
	parameter int COORD_BITS = 13
);
	logic                         valid;
	logic                         ready;
	logic                         valid_res;
	logic signed [COORD_BITS-1:0] stamp_x;
	logic signed [COORD_BITS-1:0] stamp_y;
	logic [15:0]                  stamp_color;
	logic                         last;

	modport source (
		output valid, valid_res, stamp_x, stamp_y, stamp_color, last,
		input  ready
	);

	modport sink (
		input  valid, valid_res, stamp_x, stamp_y, stamp_color, last,
		output ready
	);
endinterface

`default_nettype wire

@@ hdl/bresenham_line_2x2_stamper_unit.sv @@
// An accepted command beat passes through the input register (s1) and then the result register (s2) to res.
// Throughput: one command beat per cycle while res accepts; each step depends only on the line
// state written by the previous beat, updated as that beat enters the result register.
// Reset (arst_n low) empties the input and result registers and leaves the
// stepper idle; a step before the first load returns valid_res = 0.
`default_nettype none

module bresenham_line_2x2_stamper_unit #(
	parameter int COORD_BITS = 13
) (
	input wire logic clk,
	input wire logic arst_n,
	blss_cmd_if.sink   cmd,
	blss_res_if.source res
);
	import blss_pkg::*;

	localparam int CW = COORD_BITS;

	logic                  valid_s1;
	action_t               action_s1;
	logic signed [CW-1:0]  start_x_s1, start_y_s1, end_x_s1, end_y_s1;
	logic [COLOR_BITS-1:0] pen_color_s1;

	logic                  valid_s2;
	logic                  valid_res_s2;
	logic signed [CW-1:0]  stamp_x_s2, stamp_y_s2;
	logic [COLOR_BITS-1:0] stamp_color_s2;
	logic                  last_s2;

	logic                  advance;
	logic                  core_valid_res;
	logic signed [CW-1:0]  core_stamp_x, core_stamp_y;
	logic [COLOR_BITS-1:0] core_stamp_color;
	logic                  core_last;

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			action_s1    <= action_t'(cmd.action);
			start_x_s1   <= cmd.start_x;
			start_y_s1   <= cmd.start_y;
			end_x_s1     <= cmd.end_x;
			end_y_s1     <= cmd.end_y;
			pen_color_s1 <= cmd.pen_color;
		end
		if (advance) begin
			valid_res_s2   <= core_valid_res;
			stamp_x_s2     <= core_stamp_x;
			stamp_y_s2     <= core_stamp_y;
			stamp_color_s2 <= core_stamp_color;
			last_s2        <= core_last;
		end
	end

	blss_core #(
		.COORD_BITS(COORD_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.action     (action_s1),
		.start_x    (start_x_s1),
		.start_y    (start_y_s1),
		.end_x      (end_x_s1),
		.end_y      (end_y_s1),
		.pen_color  (pen_color_s1),
		.valid_res  (core_valid_res),
		.stamp_x    (core_stamp_x),
		.stamp_y    (core_stamp_y),
		.stamp_color(core_stamp_color),
		.last       (core_last)
	);

	assign res.valid       = valid_s2;
	assign res.valid_res   = valid_res_s2;
	assign res.stamp_x     = stamp_x_s2;
	assign res.stamp_y     = stamp_y_s2;
	assign res.stamp_color = stamp_color_s2;
	assign res.last        = last_s2;
endmodule

`default_nettype wire

@@ hdl/blss_setup.sv @@
`default_nettype none

module blss_setup #(
	parameter int COORD_BITS = 13
) (
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	output logic        [COORD_BITS-1:0]      dx_mag,
	output logic signed [COORD_BITS:0]        dy_neg,
	output logic                              step_x_neg,
	output logic                              step_y_neg,
	output logic signed [COORD_BITS+1:0]      err_init
);
	localparam int CW = COORD_BITS;

	logic signed [CW:0] dx;
	logic signed [CW:0] dy;
	logic signed [CW:0] dx_abs;

	always_comb begin
		dx         = (CW+1)'(end_x) - (CW+1)'(start_x);
		dy         = (CW+1)'(end_y) - (CW+1)'(start_y);
		dx_abs     = dx[CW] ? -dx : dx;
		dx_mag     = dx_abs[CW-1:0];
		dy_neg     = dy[CW] ? dy : -dy;
		step_x_neg = !(start_x < end_x);
		step_y_neg = !(start_y < end_y);
		err_init   = $signed({2'b00, dx_mag}) + (CW+2)'(dy_neg);
	end
endmodule

`default_nettype wire

@@ hdl/blss_core.sv @@
`default_nettype none

module blss_core #(
	parameter int COORD_BITS = 13
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         fire,
	input  wire blss_pkg::action_t            action,
	input  wire logic signed [COORD_BITS-1:0] start_x,
	input  wire logic signed [COORD_BITS-1:0] start_y,
	input  wire logic signed [COORD_BITS-1:0] end_x,
	input  wire logic signed [COORD_BITS-1:0] end_y,
	input  wire logic [15:0]                  pen_color,
	output logic                              valid_res,
	output logic signed [COORD_BITS-1:0]      stamp_x,
	output logic signed [COORD_BITS-1:0]      stamp_y,
	output logic [15:0]                       stamp_color,
	output logic                              last
);
	import blss_pkg::*;

	localparam int CW = COORD_BITS;
	localparam logic [CW-1:0] ONE = CW'(1);

	logic signed [CW-1:0] cur_x_q, cur_y_q, goal_x_q, goal_y_q;
	logic        [CW-1:0] dx_mag_q;
	logic signed [CW:0]   dy_neg_q;
	logic                 step_x_neg_q, step_y_neg_q;
	logic signed [CW+1:0] err_q;
	logic [COLOR_BITS-1:0] color_q;
	logic                 busy_q;

	logic        [CW-1:0] ld_dx_mag;
	logic signed [CW:0]   ld_dy_neg;
	logic                 ld_step_x_neg, ld_step_y_neg;
	logic signed [CW+1:0] ld_err;

	logic signed [CW+2:0] e2, dy_ext, dx_ext;
	logic                 move_x, move_y;
	logic signed [CW+1:0] add_x, add_y, err_step;
	logic signed [CW-1:0] cur_x_step, cur_y_step;

	logic                 is_load, take;
	logic signed [CW-1:0] cur_x_d, cur_y_d, goal_x_d, goal_y_d;
	logic signed [CW+1:0] err_d;
	logic                 at_end;

	blss_setup #(
		.COORD_BITS(COORD_BITS)
	) u_setup (
		.start_x   (start_x),
		.start_y   (start_y),
		.end_x     (end_x),
		.end_y     (end_y),
		.dx_mag    (ld_dx_mag),
		.dy_neg    (ld_dy_neg),
		.step_x_neg(ld_step_x_neg),
		.step_y_neg(ld_step_y_neg),
		.err_init  (ld_err)
	);

	always_comb begin
		e2         = {err_q, 1'b0};
		dy_ext     = (CW+3)'(dy_neg_q);
		dx_ext     = $signed({3'b000, dx_mag_q});
		move_x     = e2 >= dy_ext;
		move_y     = e2 <= dx_ext;
		add_x      = move_x ? (CW+2)'(dy_neg_q) : '0;
		add_y      = move_y ? $signed({2'b00, dx_mag_q}) : '0;
		err_step   = err_q + add_x + add_y;
		cur_x_step = move_x ? (cur_x_q + (step_x_neg_q ? '1 : ONE)) : cur_x_q;
		cur_y_step = move_y ? (cur_y_q + (step_y_neg_q ? '1 : ONE)) : cur_y_q;

		is_load  = action == ACT_LOAD;
		take     = is_load || busy_q;
		cur_x_d  = is_load ? start_x : cur_x_step;
		cur_y_d  = is_load ? start_y : cur_y_step;
		goal_x_d = is_load ? end_x : goal_x_q;
		goal_y_d = is_load ? end_y : goal_y_q;
		err_d    = is_load ? ld_err : err_step;
		at_end   = (cur_x_d == goal_x_d) && (cur_y_d == goal_y_d);

		valid_res   = take;
		stamp_x     = take ? {cur_x_d[CW-1:1], 1'b0} : '0;
		stamp_y     = take ? {cur_y_d[CW-1:1], 1'b0} : '0;
		stamp_color = take ? (is_load ? pen_color : color_q) : '0;
		last        = take && at_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (fire && take) begin
			busy_q <= !at_end;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && take) begin
			cur_x_q  <= cur_x_d;
			cur_y_q  <= cur_y_d;
			goal_x_q <= goal_x_d;
			goal_y_q <= goal_y_d;
			err_q    <= err_d;
			if (is_load) begin
				dx_mag_q     <= ld_dx_mag;
				dy_neg_q     <= ld_dy_neg;
				step_x_neg_q <= ld_step_x_neg;
				step_y_neg_q <= ld_step_y_neg;
				color_q      <= pen_color;
			end
		end
	end
endmodule

`default_nettype wire

@@ hdl/blss_checker.sv @@
`default_nettype none
`include "bresenham_line_2x2_stamper_unit_defines.svh"

module blss_checker #(
	parameter int COORD_BITS = 13
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  res_valid,
	input wire logic                  res_ready,
	input wire logic                  valid_res,
	input wire logic [COORD_BITS-1:0] stamp_x,
	input wire logic [COORD_BITS-1:0] stamp_y,
	input wire logic [15:0]           stamp_color,
	input wire logic                  last
);
	// hold a stalled result beat
	`BLSS_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(stamp_x) && $stable(stamp_y) && $stable(stamp_color) && $stable(last), "stalled result beat changed")

	`BLSS_ASSERT_IMP(a_last_needs_stamp, clk, arst_n, res_valid && last, valid_res, "last flagged on a result without a stamp")

	`BLSS_ASSERT_IMP(a_idle_zero, clk, arst_n, res_valid && !valid_res, stamp_x == '0 && stamp_y == '0 && stamp_color == '0, "idle step result carries nonzero fields")

	`BLSS_ASSERT_IMP(a_cell_aligned, clk, arst_n, res_valid && valid_res, !stamp_x[0] && !stamp_y[0], "stamp not aligned to a 2x2 cell")
endmodule

bind bresenham_line_2x2_stamper_unit blss_checker #(
	.COORD_BITS(COORD_BITS)
) u_blss_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (res.valid),
	.res_ready  (res.ready),
	.valid_res  (res.valid_res),
	.stamp_x    (res.stamp_x),
	.stamp_y    (res.stamp_y),
	.stamp_color(res.stamp_color),
	.last       (res.last)
);

`default_nettype wire

@@ bench/tb_bresenham_line_2x2_stamper_unit.sv @@
`default_nettype none

module tb_bresenham_line_2x2_stamper_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import blss_pkg::*;

	localparam int CB = 13;
	localparam int COORD_HI = 2**(CB-1) - 1;
	localparam int COORD_LO = -(2**(CB-1));
	localparam int ITEM_GOAL = 1550;
	localparam int RUN_LIMIT = 200000;
	localparam int SETTLE = 8;
	localparam int QUIET_FROM = 600;
	localparam int QUIET_TO = 1400;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct packed {
		action_t                 action;
		coord_t                  sx;
		coord_t                  sy;
		coord_t                  ex;
		coord_t                  ey;
		logic [COLOR_BITS-1:0]   color;
	} line_cmd_t;

	typedef struct packed {
		logic                    valid_res;
		coord_t                  x;
		coord_t                  y;
		logic [COLOR_BITS-1:0]   color;
		logic                    last;
	} stamp_t;

	logic clk = 1'b0;
	logic arst_n;
	int   cycles = 0;
	int   faults = 0;

	line_cmd_t line_cmds[$];
	stamp_t    stamps_due[$];
	line_cmd_t sent_cmd;
	line_cmd_t next_cmd;
	stamp_t    want;
	stamp_t    got;

	// line state of the predictor
	coord_t                 pos_x, pos_y, goal_x, goal_y;
	logic [CB-1:0]          run_x;
	logic signed [CB:0]     rise_neg;
	logic signed [CB+1:0]   err;
	logic                   x_back, y_back;
	logic                   drawing = 1'b0;
	logic [COLOR_BITS-1:0]  ink;

	blss_cmd_if #(.COORD_BITS(CB)) cmd_bus ();
	blss_res_if #(.COORD_BITS(CB)) res_bus ();

	bresenham_line_2x2_stamper_unit #(.COORD_BITS(CB)) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_bus.sink),
		.res    (res_bus.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic stamp_t bresenham_next_stamp(line_cmd_t c);
		int     dx, dy, e2;
		stamp_t r;
		r = '0;
		if (c.action == ACT_LOAD) begin
			pos_x = c.sx;
			pos_y = c.sy;
			goal_x = c.ex;
			goal_y = c.ey;
			ink = c.color;
			dx = int'(goal_x) - int'(pos_x);
			dy = int'(goal_y) - int'(pos_y);
			run_x = CB'(mag(dx));
			rise_neg = (CB+1)'(-mag(dy));
			x_back = !(pos_x < goal_x);
			y_back = !(pos_y < goal_y);
			err = (CB+2)'(int'(run_x) + int'(rise_neg));
		end else begin
			if (!drawing)
				return r;
			e2 = 2 * int'(err);
			if (e2 >= int'(rise_neg)) begin
				err = (CB+2)'(int'(err) + int'(rise_neg));
				pos_x = coord_t'(int'(pos_x) + (x_back ? -1 : 1));
			end
			if (e2 <= int'(run_x)) begin
				err = (CB+2)'(int'(err) + int'(run_x));
				pos_y = coord_t'(int'(pos_y) + (y_back ? -1 : 1));
			end
		end
		drawing = !((pos_x == goal_x) && (pos_y == goal_y));
		r.valid_res = 1'b1;
		r.x = {pos_x[CB-1:1], 1'b0};
		r.y = {pos_y[CB-1:1], 1'b0};
		r.color = ink;
		r.last = !drawing;
		return r;
	endfunction

	function automatic bit idle_roll();
		return (cycles < QUIET_FROM || cycles >= QUIET_TO) && ($urandom_range(99) < 26);
	endfunction

	function automatic coord_t any_coord();
		return coord_t'($urandom_range(2**CB - 1));
	endfunction

	function automatic coord_t near(coord_t base, int span);
		int d, v;
		d = int'($urandom_range(2 * span)) - span;
		v = int'(base) + d;
		if (v > COORD_HI || v < COORD_LO)
			v = int'(base) - d;
		return coord_t'(v);
	endfunction

	task automatic add_load(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
			logic [COLOR_BITS-1:0] color);
		line_cmd_t c;
		c.action = ACT_LOAD;
		c.sx = sx;
		c.sy = sy;
		c.ex = ex;
		c.ey = ey;
		c.color = color;
		line_cmds.push_back(c);
	endtask

	task automatic add_steps(int n);
		line_cmd_t c;
		c = '0;
		c.action = ACT_STEP;
		repeat (n) begin
			c.sx = any_coord();
			c.sy = any_coord();
			c.ex = any_coord();
			c.ey = any_coord();
			c.color = COLOR_BITS'($urandom);
			line_cmds.push_back(c);
		end
	endtask

	// extra > 0 steps past the end point, extra < 0 cuts the line short
	task automatic add_line(coord_t sx, coord_t sy, coord_t ex, coord_t ey,
			logic [COLOR_BITS-1:0] color, int extra);
		int n;
		n = mag(int'(ex) - int'(sx));
		if (mag(int'(ey) - int'(sy)) > n)
			n = mag(int'(ey) - int'(sy));
		n = n + extra;
		add_load(sx, sy, ex, ey, color);
		add_steps((n < 0) ? 0 : n);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_bus.valid <= 1'b0;
			cmd_bus.action <= ACT_LOAD;
			cmd_bus.start_x <= '0;
			cmd_bus.start_y <= '0;
			cmd_bus.end_x <= '0;
			cmd_bus.end_y <= '0;
			cmd_bus.pen_color <= '0;
		end else begin
			if (cmd_bus.valid && cmd_bus.ready) begin
				sent_cmd.action = action_t'(cmd_bus.action);
				sent_cmd.sx = cmd_bus.start_x;
				sent_cmd.sy = cmd_bus.start_y;
				sent_cmd.ex = cmd_bus.end_x;
				sent_cmd.ey = cmd_bus.end_y;
				sent_cmd.color = cmd_bus.pen_color;
				stamps_due.push_back(bresenham_next_stamp(sent_cmd));
			end
			if (!cmd_bus.valid || cmd_bus.ready) begin
				if (line_cmds.size() > 0 && !idle_roll()) begin
					next_cmd = line_cmds.pop_front();
					cmd_bus.valid <= 1'b1;
					cmd_bus.action <= next_cmd.action;
					cmd_bus.start_x <= next_cmd.sx;
					cmd_bus.start_y <= next_cmd.sy;
					cmd_bus.end_x <= next_cmd.ex;
					cmd_bus.end_y <= next_cmd.ey;
					cmd_bus.pen_color <= next_cmd.color;
				end else begin
					cmd_bus.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				got.valid_res = res_bus.valid_res;
				got.x = res_bus.stamp_x;
				got.y = res_bus.stamp_y;
				got.color = res_bus.stamp_color;
				got.last = res_bus.last;
				if (stamps_due.size() == 0) begin
					faults++;
					if (faults < 100)
						$display("%0t unexpected beat: valid_res=%0d x=%0d y=%0d color=%h last=%0d",
							$time, got.valid_res, got.x, got.y, got.color, got.last);
				end else begin
					want = stamps_due.pop_front();
					if (got.valid_res !== want.valid_res || got.x !== want.x ||
						got.y !== want.y || got.color !== want.color ||
						got.last !== want.last) begin
						faults++;
						if (faults < 100)
							$display({"%0t mismatch: expected valid_res=%0d x=%0d y=%0d ",
								"color=%h last=%0d, actual valid_res=%0d x=%0d y=%0d ",
								"color=%h last=%0d"},
								$time, want.valid_res, want.x, want.y, want.color, want.last,
								got.valid_res, got.x, got.y, got.color, got.last);
					end
				end
			end
			res_bus.ready <= !idle_roll();
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		int     pick, span, extra, k, len;
		coord_t sx, sy, ex, ey;
		logic [COLOR_BITS-1:0] color;

		arst_n = 1'b0;

		// step before any line, a point line, then a step while idle
		add_steps(1);
		add_line(coord_t'(COORD_HI), coord_t'(COORD_HI), coord_t'(COORD_HI),
			coord_t'(COORD_HI), 16'hFFFF, 1);
		// corner to corner, dropped by a new load while busy
		add_line(coord_t'(COORD_LO), coord_t'(COORD_LO), coord_t'(COORD_HI),
			coord_t'(COORD_HI), 16'hFFFF, -8188);
		add_line(coord_t'(COORD_HI), coord_t'(COORD_LO), coord_t'(COORD_LO),
			coord_t'(COORD_HI), 16'h0000, -8188);
		add_line(coord_t'(COORD_HI), coord_t'(COORD_HI), coord_t'(COORD_LO),
			coord_t'(COORD_LO), 16'hA5A5, -8190);
		add_line(13'sd0, 13'sd0, 13'sd3, -13'sd1, 16'h5A5A, 1);
		add_line(-13'sd3, 13'sd2, -13'sd4, -13'sd3, 16'h1234, 0);
		add_line(13'sd5, -13'sd7, 13'sd1, -13'sd7, 16'hF800, 0);
		add_line(-13'sd1, 13'sd1, -13'sd1, 13'sd4, 16'h07E0, 0);

		while (line_cmds.size() < ITEM_GOAL) begin
			pick = $urandom_range(99);
			sx = any_coord();
			sy = any_coord();
			color = COLOR_BITS'($urandom);
			if (pick < 72) begin
				span = ($urandom_range(29) == 0) ? 120 : 12;
				ex = near(sx, span);
				ey = near(sy, span);
				if ($urandom_range(9) == 0)
					ex = sx;
				else if ($urandom_range(9) == 0)
					ey = sy;
				len = mag(int'(ex) - int'(sx));
				if (mag(int'(ey) - int'(sy)) > len)
					len = mag(int'(ey) - int'(sy));
				extra = 0;
				k = $urandom_range(9);
				if (k < 2)
					extra = $urandom_range(2) + 1;
				else if (k < 4)
					extra = -int'($urandom_range(len));
				add_line(sx, sy, ex, ey, color, extra);
			end else if (pick < 88) begin
				add_load(sx, sy, any_coord(), any_coord(), color);
				add_steps($urandom_range(3));
			end else begin
				add_steps($urandom_range(2) + 1);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (line_cmds.size() > 0 || cmd_bus.valid)
			@(posedge clk);
		while (stamps_due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (faults == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

@@ bresenham_line_2x2_stamper_unit.f @@
+incdir+hdl
hdl/blss_pkg.sv
hdl/blss_cmd_if.sv
hdl/blss_res_if.sv
hdl/blss_setup.sv
hdl/blss_core.sv
hdl/bresenham_line_2x2_stamper_unit.sv
hdl/blss_checker.sv
bench/tb_bresenham_line_2x2_stamper_unit.sv
